// File: design/sdcd_pkg.sv
// Shared constants and helpers for the scaled delta coordinate decoder.
package sdcd_pkg;

  localparam int UNIT_W = 31;

  localparam logic [UNIT_W-1:0] UNIT_ONE_RST     = 31'd100000000;
  localparam logic [UNIT_W-1:0] UNIT_HALF_PI_RST = 31'd157079633;

  localparam logic REG_UNIT_ONE     = 1'b0;
  localparam logic REG_UNIT_HALF_PI = 1'b1;

  localparam logic ACT_HEADER = 1'b0;
  localparam logic ACT_DELTA  = 1'b1;

  localparam logic [1:0] NB_ONE   = 2'd0;
  localparam logic [1:0] NB_TWO   = 2'd1;
  localparam logic [1:0] NB_THREE = 2'd2;
  localparam logic [1:0] NB_FOUR  = 2'd3;

  typedef logic [1:0] nb_code_t;

  // Keep the low (code+1) bytes and sign-extend from the top kept bit.
  function automatic logic [31:0] sext_bytes(input logic [31:0] raw, input nb_code_t code);
    logic [31:0] v;
    case (code)
      NB_ONE:   v = {{24{raw[7]}}, raw[7:0]};
      NB_TWO:   v = {{16{raw[15]}}, raw[15:0]};
      NB_THREE: v = {{8{raw[23]}}, raw[23:0]};
      default:  v = raw;
    endcase
    return v;
  endfunction

endpackage

// File: design/scaled_delta_coordinate_decoder_top.sv
// Scaled delta coordinate decoder: header and delta items to decoded points.
// Each item steps idle, magnitude check, shift search, final; the latitude shift
//   found lies in 0..SHIFT_CAP; at or past a pole the search is skipped (shift = cap).
// A new item is taken only in idle, after the final step of the last one; the final
//   step waits while a result is unread; the search steps one shared unit per cycle.
// Reset (rst_n low, synchronous): config to defaults, point and shifts cleared.
module scaled_delta_coordinate_decoder_top #(
  parameter int SHIFT_CAP  = 16,
  parameter int COORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [sdcd_pkg::UNIT_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_action,
  input  logic [6:0]                  in_control_byte,
  input  logic signed [31:0]          in_start_lat,
  input  logic signed [31:0]          in_start_lon,
  input  logic [31:0]                 in_raw_dlon,
  input  logic [31:0]                 in_raw_dlat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          out_point_lat,
  output logic signed [31:0]          out_point_lon,
  output logic                        out_is_start
);
  import sdcd_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int SB = $clog2(SHIFT_CAP + 1);
  localparam int MW = (CB > UNIT_W) ? CB : UNIT_W;
  localparam logic [SB-1:0] CAP = SB'(SHIFT_CAP);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAG  = 2'd1;
  localparam logic [1:0] ST_ITER = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [UNIT_W-1:0] unit_one_r, unit_one_nxt;
  logic [UNIT_W-1:0] unit_half_pi_r, unit_half_pi_nxt;
  logic [CB-1:0]     cur_lat_r, cur_lat_nxt;
  logic [CB-1:0]     cur_lon_r, cur_lon_nxt;
  logic [SB-1:0]     prev_shift_r, prev_shift_nxt;
  logic [4:0]        res_shift_r, res_shift_nxt;
  nb_code_t          nb_r, nb_nxt;
  logic              is_delta_r, is_delta_nxt;
  logic [CB-1:0]     dlon_r, dlon_nxt;
  logic [UNIT_W-1:0] dk_r, dk_nxt;
  logic [SB-1:0]     k_r, k_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_lat_r, out_lat_nxt;
  logic [31:0]       out_lon_r, out_lon_nxt;
  logic              out_start_r, out_start_nxt;

  logic              in_xfer;
  logic              slot_free;
  logic [31:0]       dlat_s, dlon_s;
  logic [63:0]       dlat_w, dlon_w, slat_w, slon_w;
  logic [CB-1:0]     mag;
  logic [MW-1:0]     mag_x, hp_x, diff_x;
  logic              step_ok;
  logic [SB-1:0]     min_shift;
  logic [5:0]        lon_shift;
  logic [CB-1:0]     lon_new;
  logic [63:0]       lat_z, lon_z;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  assign dlat_s = sext_bytes(in_raw_dlat, nb_r);
  assign dlon_s = sext_bytes(in_raw_dlon, nb_r);

  always_comb begin
    dlat_w = {{32{dlat_s[31]}}, dlat_s};
    dlon_w = {{32{dlon_s[31]}}, dlon_s};
    slat_w = {{32{in_start_lat[31]}}, in_start_lat};
    slon_w = {{32{in_start_lon[31]}}, in_start_lon};
  end

  // magnitude of the latitude, modulo 2^CB
  assign mag    = cur_lat_r[CB-1] ? (CB'(0) - cur_lat_r) : cur_lat_r;
  assign mag_x  = MW'(mag);
  assign hp_x   = MW'(unit_half_pi_r);
  assign diff_x = hp_x - mag_x;

  // shared unit: the shift is below the cap and doubling the divisor still fits under unit_one
  assign step_ok = (k_r < CAP) && ({dk_r, 1'b0} <= {1'b0, unit_one_r});

  assign min_shift = (k_r < prev_shift_r) ? k_r : prev_shift_r;
  assign lon_shift = 6'(min_shift) + 6'(res_shift_r);
  assign lon_new   = cur_lon_r + (dlon_r << lon_shift);

  always_comb begin
    state_nxt        = state_r;
    unit_one_nxt     = unit_one_r;
    unit_half_pi_nxt = unit_half_pi_r;
    cur_lat_nxt      = cur_lat_r;
    cur_lon_nxt      = cur_lon_r;
    prev_shift_nxt   = prev_shift_r;
    res_shift_nxt    = res_shift_r;
    nb_nxt           = nb_r;
    is_delta_nxt     = is_delta_r;
    dlon_nxt         = dlon_r;
    dk_nxt           = dk_r;
    k_nxt            = k_r;
    out_valid_nxt    = out_valid_r;
    out_lat_nxt      = out_lat_r;
    out_lon_nxt      = out_lon_r;
    out_start_nxt    = out_start_r;
    lat_z            = 64'(cur_lat_r);
    lon_z            = 64'(cur_lon_r);

    if (cfg_we) begin
      if (cfg_index == REG_UNIT_ONE) unit_one_nxt = cfg_wdata;
      else unit_half_pi_nxt = cfg_wdata;
    end

    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          is_delta_nxt = (in_action == ACT_DELTA);
          if (in_action == ACT_HEADER) begin
            res_shift_nxt = in_control_byte[4:0];
            nb_nxt        = in_control_byte[6:5];
            cur_lat_nxt   = slat_w[CB-1:0];
            cur_lon_nxt   = slon_w[CB-1:0];
          end else begin
            cur_lat_nxt = cur_lat_r + (dlat_w[CB-1:0] << res_shift_r);
            dlon_nxt    = dlon_w[CB-1:0];
          end
          state_nxt = ST_MAG;
        end
      end
      ST_MAG: begin
        k_nxt = '0;
        if (mag_x >= hp_x) begin
          k_nxt     = CAP;
          state_nxt = ST_FIN;
        end else begin
          dk_nxt    = diff_x[UNIT_W-1:0];
          state_nxt = ST_ITER;
        end
      end
      ST_ITER: begin
        if (step_ok) begin
          dk_nxt = {dk_r[UNIT_W-2:0], 1'b0};
          k_nxt  = k_r + SB'(1);
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          prev_shift_nxt = k_r;
          if (is_delta_r) begin
            cur_lon_nxt = lon_new;
            lon_z       = 64'(lon_new);
          end
          out_lat_nxt   = lat_z[31:0];
          out_lon_nxt   = lon_z[31:0];
          out_start_nxt = !is_delta_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      unit_one_r     <= UNIT_ONE_RST;
      unit_half_pi_r <= UNIT_HALF_PI_RST;
      cur_lat_r      <= '0;
      cur_lon_r      <= '0;
      prev_shift_r   <= '0;
      res_shift_r    <= '0;
      nb_r           <= NB_ONE;
      k_r            <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      unit_one_r     <= unit_one_nxt;
      unit_half_pi_r <= unit_half_pi_nxt;
      cur_lat_r      <= cur_lat_nxt;
      cur_lon_r      <= cur_lon_nxt;
      prev_shift_r   <= prev_shift_nxt;
      res_shift_r    <= res_shift_nxt;
      nb_r           <= nb_nxt;
      k_r            <= k_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    is_delta_r  <= is_delta_nxt;
    dlon_r      <= dlon_nxt;
    dk_r        <= dk_nxt;
    out_lat_r   <= out_lat_nxt;
    out_lon_r   <= out_lon_nxt;
    out_start_r <= out_start_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_point_lat = out_lat_r;
  assign out_point_lon = out_lon_r;
  assign out_is_start  = out_start_r;

  a_shift_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (k_r <= CAP) && (prev_shift_r <= CAP))
    else $error("latitude shift beyond cap");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous item in flight");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_FIN))
    else $error("result raised outside final step");

  a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) && out_valid && !out_ready |=> (state_r == ST_FIN))
    else $error("result overwritten before transfer");

  a_iter_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ITER) && step_ok |=> (dk_r <= unit_one_r))
    else $error("scaled divisor grew past unit_one");

endmodule
